>>> hw/rtl/unique_key_set_table_macros.svh
// Assertion macros for the unique key set table.
// Used by ukst_dpath; they expect clk and arst_n in scope.
`ifndef UNIQUE_KEY_SET_TABLE_MACROS_SVH
`define UNIQUE_KEY_SET_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define UKST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define UKST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/ukst_pkg.sv
// Shared constants and types for the unique key set table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ukst_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 32;
	localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS = $clog2(CAPACITY + 1);

	localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

	// operation codes; the unused code behaves as a look up
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic latch;     // take the input transaction
		logic scan_rd;   // read the next stored key for comparison
		logic append;    // write the key after the held keys
		logic refuse;    // flag the insert as refused
		logic rm_rd;     // read the last held key, drop the count
		logic move_wr;   // write the last key into the freed slot
		logic load_out;  // load the result register
	} ukst_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic count_zero;
		logic scan_last;
		logic found;
		logic full;
		logic op_insert;
		logic op_remove;
		logic out_free;
	} ukst_sts_t;

endpackage

>>> hw/rtl/ukst_ctrl.sv
// Controller state machine for the unique key set table.
// Depends on ukst_pkg; drives ukst_dpath through ukst_cmd_t.
`timescale 1ns / 1ps

module ukst_ctrl import ukst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  ukst_sts_t sts,
	output ukst_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_DRAIN  = 6'b000100,
		ST_DECIDE = 6'b001000,
		ST_MOVE   = 6'b010000,
		ST_DONE   = 6'b100000
	} ukst_state_t;

	ukst_state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = sts.count_zero ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = ST_DONE;
				if (sts.op_insert && !sts.found) begin
					if (sts.full) begin
						cmd.refuse = 1'b1;
					end else begin
						cmd.append = 1'b1;
					end
				end else if (sts.op_remove && sts.found) begin
					cmd.rm_rd = 1'b1;
					state_d   = ST_MOVE;
				end
			end
			ST_MOVE: begin
				cmd.move_wr = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/ukst_dpath.sv
// Datapath for the unique key set table: key memory, count, scan and result register.
// Depends on ukst_pkg and unique_key_set_table_macros.svh; steered by ukst_ctrl.
`timescale 1ns / 1ps
`include "unique_key_set_table_macros.svh"

module ukst_dpath import ukst_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          op,
	input  logic [31:0]         key,
	input  logic                out_stall,
	output logic                out_valid,
	output logic                found,
	output logic                full_refused,
	output logic [CNT_BITS-1:0] count,
	input  ukst_cmd_t           cmd,
	output ukst_sts_t           sts
);

	logic [KEY_BITS-1:0] mem [CAPACITY];

	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CNT_BITS-1:0] count_q;
	logic [IDX_BITS-1:0] scan_idx_q;
	logic [IDX_BITS-1:0] slot_q;
	logic                found_q;
	logic                refused_q;
	logic [KEY_BITS-1:0] rd_data_q;
	logic                rd_vld_s1;
	logic [IDX_BITS-1:0] addr_s1;
	logic                out_valid_q;
	logic                out_found_q;
	logic                out_refused_q;
	logic [CNT_BITS-1:0] out_count_q;

	logic [CNT_BITS-1:0] last_cnt;
	logic [IDX_BITS-1:0] rd_addr;
	logic                rd_en;
	logic [IDX_BITS-1:0] wr_addr;
	logic [KEY_BITS-1:0] wr_data;
	logic                wr_en;
	logic                hit;

	assign last_cnt = count_q - CNT_BITS'(1);
	assign hit      = rd_vld_s1 && (rd_data_q == key_q);

	// status towards the controller
	assign sts.count_zero = (count_q == '0);
	assign sts.scan_last  = ((CNT_BITS'(scan_idx_q) + CNT_BITS'(1)) == count_q);
	assign sts.found      = found_q;
	assign sts.full       = (count_q >= CAP_CNT);
	assign sts.op_insert  = (op_q == OP_INSERT);
	assign sts.op_remove  = (op_q == OP_REMOVE);
	assign sts.out_free   = !out_valid_q || !out_stall;

	// select memory ports
	assign rd_en   = cmd.scan_rd || cmd.rm_rd;
	assign rd_addr = cmd.rm_rd ? last_cnt[IDX_BITS-1:0] : scan_idx_q;
	assign wr_en   = cmd.append || cmd.move_wr;
	assign wr_addr = cmd.move_wr ? slot_q : count_q[IDX_BITS-1:0];
	assign wr_data = cmd.move_wr ? rd_data_q : key_q;

	// key memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// capture the transaction and track the scan
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= op;
			key_q <= key[KEY_BITS-1:0];
		end
		addr_s1 <= scan_idx_q;
		if (hit) begin
			slot_q <= addr_s1;
		end
	end

	// advance scan index and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			found_q    <= 1'b0;
			refused_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.latch) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
				refused_q  <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					scan_idx_q <= scan_idx_q + IDX_BITS'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
				if (cmd.refuse) begin
					refused_q <= 1'b1;
				end
			end
		end
	end

	// held key count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.append) begin
			count_q <= count_q + CNT_BITS'(1);
		end else if (cmd.rm_rd) begin
			count_q <= last_cnt;
		end
	end

	// result register, held until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_found_q   <= found_q;
			out_refused_q <= refused_q;
			out_count_q   <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = out_found_q;
	assign full_refused = out_refused_q;
	assign count        = out_count_q;

	`UKST_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP_CNT, "count above capacity")
	`UKST_ASSERT_NOW(a_append_room, cmd.append, count_q < CAP_CNT, "append into full table")
	`UKST_ASSERT_NOW(a_refuse_full, cmd.refuse, count_q == CAP_CNT, "refused while not full")
	`UKST_ASSERT_NOW(a_remove_held, cmd.rm_rd, found_q && count_q != '0, "remove without a match")
	`UKST_ASSERT_NEXT(a_load_valid, cmd.load_out, out_valid_q, "result not presented")

endmodule

>>> hw/rtl/unique_key_set_table.sv
// Top level of the unique key set table: controller plus datapath.
// Depends on ukst_pkg, ukst_ctrl and ukst_dpath.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------
//   input   | in_valid, in_stall   | op[1:0], key[31:0]
//   output  | out_valid, out_stall | found, full_refused, count[4:0]
//
// A transaction steps through accept, a scan of one stored key per cycle, a drain, a decision,
// a move on a remove that hits, and the result load, which waits while the output is stalled.
// An empty table skips the scan and drain.
// Reset clears the count and control; the key memory is not cleared.
// The input is stalled while a transaction is in work; a stalled output holds its result,
// and the next transaction may be taken meanwhile.
`timescale 1ns / 1ps

module unique_key_set_table import ukst_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [31:0]         key,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                found,
	output logic                full_refused,
	output logic [CNT_BITS-1:0] count
);

	ukst_cmd_t cmd;
	ukst_sts_t sts;

	ukst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ukst_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.key          (key),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.found        (found),
		.full_refused (full_refused),
		.count        (count),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
